// ===== sv/twlbt_pkg.sv =====
package twlbt_pkg;

    // Field and register widths
    localparam int FUNC_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int INDEX_W   = 16;
    localparam int BITPOS_W  = 3;
    localparam int ECODE_W   = 4;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    // Width of the wait counter; it saturates at its all-ones value.
    localparam int CNT_W = 24;

    // Phase codes; a timeout reports the phase it happened in as the error code.
    localparam int PHASE_W = 4;
    localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd0;
    localparam logic [PHASE_W-1:0] PH_TX_IDLE    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_TX1_TIPLO  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_TX1_TIPHI  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_TX0_RINGLO = 4'd4;
    localparam logic [PHASE_W-1:0] PH_TX0_RINGHI = 4'd5;
    localparam logic [PHASE_W-1:0] PH_RX_START   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_RX1_RINGHI = 4'd7;
    localparam logic [PHASE_W-1:0] PH_RX0_TIPHI  = 4'd8;

    // Function codes of an input item
    localparam logic [FUNC_W-1:0] FN_TICK = 2'd0;
    localparam logic [FUNC_W-1:0] FN_SEND = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RECV = 2'd2;

    // Line drive bits
    typedef logic [1:0] drive_t;
    localparam drive_t DRV_NONE = 2'b00;
    localparam drive_t DRV_RING = 2'b01;
    localparam drive_t DRV_TIP  = 2'b10;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_HANDSHAKE_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIMEOUT     = 2'd1;
    localparam logic [CFG_W-1:0] HANDSHAKE_TIMEOUT_RST = 24'd4000;
    localparam logic [CFG_W-1:0] START_TIMEOUT_RST     = 24'd30000;

endpackage

// ===== sv/two_wire_link_bit_transceiver_top.sv =====
// Channel | Handshake           | Payload
// --------+---------------------+--------------------------------------------------
// in      | in_valid / in_stall | func, tx_byte, byte_index, ring_level, tip_level
// out     | out_valid/out_stall | ring_pull_low, tip_pull_low, busy_res, done_res,
//         |                     | rx_byte, error_code, error_bit, error_byte
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Each item is one line sampling tick. The edge that accepts an item updates the state
// machine and loads its result into the output register, which offers it from the next cycle.
// One item is accepted per cycle; the output register alone sets that figure.
// An item is accepted while the output register is empty or being taken, so a
// stalled output stalls the input. Reset clears the state, the control flags
// and loads the timeout registers with their default values.
module two_wire_link_bit_transceiver_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [twlbt_pkg::FUNC_W-1:0]        func,
    input  logic [twlbt_pkg::BYTE_W-1:0]        tx_byte,
    input  logic [twlbt_pkg::INDEX_W-1:0]       byte_index,
    input  logic                                ring_level,
    input  logic                                tip_level,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                ring_pull_low,
    output logic                                tip_pull_low,
    output logic                                busy_res,
    output logic                                done_res,
    output logic [twlbt_pkg::BYTE_W-1:0]        rx_byte,
    output logic [twlbt_pkg::ECODE_W-1:0]       error_code,
    output logic [twlbt_pkg::BITPOS_W-1:0]      error_bit,
    output logic [twlbt_pkg::INDEX_W-1:0]       error_byte,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [twlbt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [twlbt_pkg::CFG_W-1:0]         cfg_data
);
    import twlbt_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0] hs_timeout_reg;
    logic [CFG_W-1:0] start_timeout_reg;

    // Link state
    logic [PHASE_W-1:0]  phase_reg,  phase_next;
    logic [BITPOS_W-1:0] bitpos_reg, bitpos_next;
    logic [BYTE_W-1:0]   shift_reg,  shift_next;
    logic [CNT_W-1:0]    cnt_reg,    cnt_next;
    logic [INDEX_W-1:0]  index_reg,  index_next;
    drive_t              drive_reg,  drive_next;

    // Result of the current tick
    logic                done_next;
    logic [BYTE_W-1:0]   rxb_next;
    logic [ECODE_W-1:0]  ecode_next;
    logic [BITPOS_W-1:0] ebit_next;
    logic [INDEX_W-1:0]  ebyte_next;

    logic                out_valid_reg, out_valid_next;
    logic                take;
    logic                met;
    logic                bit_end;
    logic                timed_out;
    logic [CFG_W-1:0]    limit;

    // Handshake: the output register decouples the two sides.
    assign in_stall  = out_valid_reg & out_stall;
    assign take      = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_timeout_reg    <= HANDSHAKE_TIMEOUT_RST;
            start_timeout_reg <= START_TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_HANDSHAKE_TIMEOUT)
            begin
                hs_timeout_reg <= cfg_data;
            end
            else if (cfg_index == REG_START_TIMEOUT)
            begin
                start_timeout_reg <= cfg_data;
            end
        end
    end

    // The wait fails for good once the counter reaches the limit or saturates.
    assign timed_out = (32'(cnt_reg) >= 32'(limit)) || (&cnt_reg);

    // Per-tick state machine.
    always_comb
    begin
        phase_next  = phase_reg;
        bitpos_next = bitpos_reg;
        shift_next  = shift_reg;
        cnt_next    = cnt_reg;
        index_next  = index_reg;
        drive_next  = drive_reg;
        done_next   = 1'b0;
        rxb_next    = '0;
        ecode_next  = '0;
        ebit_next   = '0;
        ebyte_next  = '0;
        met         = 1'b0;
        bit_end     = 1'b0;
        limit       = hs_timeout_reg;

        case (phase_reg)
            PH_IDLE:
            begin
                if (func == FN_SEND || func == FN_RECV)
                begin
                    index_next  = byte_index;
                    bitpos_next = '0;
                    cnt_next    = '0;
                    drive_next  = DRV_NONE;
                    shift_next  = (func == FN_SEND) ? tx_byte : '0;
                    phase_next  = (func == FN_SEND) ? PH_TX_IDLE : PH_RX_START;
                end
            end
            PH_TX_IDLE:
            begin
                met = ring_level & tip_level;
                if (met)
                begin
                    if (shift_reg[0])
                    begin
                        drive_next = DRV_RING;
                        phase_next = PH_TX1_TIPLO;
                    end
                    else
                    begin
                        drive_next = DRV_TIP;
                        phase_next = PH_TX0_RINGLO;
                    end
                end
            end
            PH_TX1_TIPLO:
            begin
                met = ~tip_level;
                if (met)
                begin
                    drive_next = DRV_NONE;
                    phase_next = PH_TX1_TIPHI;
                end
            end
            PH_TX1_TIPHI:
            begin
                met = tip_level;
                if (met)
                begin
                    shift_next = {1'b0, shift_reg[BYTE_W-1:1]};
                    bit_end    = 1'b1;
                end
            end
            PH_TX0_RINGLO:
            begin
                met = ~ring_level;
                if (met)
                begin
                    drive_next = DRV_NONE;
                    phase_next = PH_TX0_RINGHI;
                end
            end
            PH_TX0_RINGHI:
            begin
                met = ring_level;
                if (met)
                begin
                    shift_next = {1'b0, shift_reg[BYTE_W-1:1]};
                    bit_end    = 1'b1;
                end
            end
            PH_RX_START:
            begin
                limit = start_timeout_reg;
                met   = ~(ring_level & tip_level);
                if (met)
                begin
                    // Ring low with tip high is a one; anything else is a zero.
                    if (!ring_level && tip_level)
                    begin
                        shift_next = {1'b1, shift_reg[BYTE_W-1:1]};
                        drive_next = DRV_TIP;
                        phase_next = PH_RX1_RINGHI;
                    end
                    else
                    begin
                        shift_next = {1'b0, shift_reg[BYTE_W-1:1]};
                        drive_next = DRV_RING;
                        phase_next = PH_RX0_TIPHI;
                    end
                end
            end
            PH_RX1_RINGHI:
            begin
                met = ring_level;
                if (met)
                begin
                    drive_next = DRV_NONE;
                    bit_end    = 1'b1;
                end
            end
            PH_RX0_TIPHI:
            begin
                met = tip_level;
                if (met)
                begin
                    drive_next = DRV_NONE;
                    bit_end    = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                drive_next = DRV_NONE;
            end
        endcase

        // Wait bookkeeping, bit completion and timeout, on the phase just entered.
        // A start tick counts as a first failed tick of its wait.
        if (phase_next != PH_IDLE)
        begin
            if (met)
            begin
                cnt_next = '0;
                if (bit_end)
                begin
                    if (&bitpos_reg)
                    begin
                        done_next   = 1'b1;
                        rxb_next    = (phase_next >= PH_RX_START) ? shift_next : '0;
                        phase_next  = PH_IDLE;
                        bitpos_next = '0;
                    end
                    else
                    begin
                        bitpos_next = bitpos_reg + 1'b1;
                        phase_next  = (phase_next >= PH_RX_START) ? PH_RX_START : PH_TX_IDLE;
                    end
                end
            end
            else if (phase_reg == PH_IDLE ? (hs_timeout_reg == '0) : timed_out)
            begin
                ecode_next  = phase_next;
                ebit_next   = bitpos_next;
                ebyte_next  = index_next;
                phase_next  = PH_IDLE;
                drive_next  = DRV_NONE;
                cnt_next    = '0;
                bitpos_next = '0;
            end
            else if (phase_reg == PH_IDLE)
            begin
                cnt_next = CNT_W'(1);
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // State registers, updated on every accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            bitpos_reg <= '0;
            shift_reg  <= '0;
            cnt_reg    <= '0;
            index_reg  <= '0;
            drive_reg  <= DRV_NONE;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            bitpos_reg <= bitpos_next;
            shift_reg  <= shift_next;
            cnt_reg    <= cnt_next;
            index_reg  <= index_next;
            drive_reg  <= drive_next;
        end
    end

    // Output valid flag.
    always_comb
    begin
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ring_pull_low <= drive_next[0];
            tip_pull_low  <= drive_next[1];
            busy_res      <= (phase_next != PH_IDLE);
            done_res      <= done_next;
            rx_byte       <= rxb_next;
            error_code    <= ecode_next;
            error_bit     <= ebit_next;
            error_byte    <= ebyte_next;
        end
    end

endmodule

// ===== bench/twlbt_checker.sv =====
`timescale 1ns / 100ps

// Watches the item, result and register channels of the transceiver, keeps its
// own copy of the line state machine, and compares every result with the oldest
// predicted one.
module twlbt_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [twlbt_pkg::FUNC_W-1:0]    func,
    input  logic [twlbt_pkg::BYTE_W-1:0]    tx_byte,
    input  logic [twlbt_pkg::INDEX_W-1:0]   byte_index,
    input  logic                            ring_level,
    input  logic                            tip_level,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic                            ring_pull_low,
    input  logic                            tip_pull_low,
    input  logic                            busy_res,
    input  logic                            done_res,
    input  logic [twlbt_pkg::BYTE_W-1:0]    rx_byte,
    input  logic [twlbt_pkg::ECODE_W-1:0]   error_code,
    input  logic [twlbt_pkg::BITPOS_W-1:0]  error_bit,
    input  logic [twlbt_pkg::INDEX_W-1:0]   error_byte,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [twlbt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [twlbt_pkg::CFG_W-1:0]     cfg_data,
    output int                              fail_count,
    output int                              pending,
    output logic                            link_busy
);
    import twlbt_pkg::*;

    typedef struct packed {
        logic                ring_pull;
        logic                tip_pull;
        logic                busy;
        logic                done;
        logic [BYTE_W-1:0]   rx;
        logic [ECODE_W-1:0]  ecode;
        logic [BITPOS_W-1:0] ebit;
        logic [INDEX_W-1:0]  ebyte;
    } line_result_t;

    // Predicted state of the transceiver and its timeout settings
    logic [PHASE_W-1:0]  ph;
    logic [BITPOS_W-1:0] bit_pos;
    logic [BYTE_W-1:0]   shreg;
    logic [CNT_W-1:0]    wait_cnt;
    logic [INDEX_W-1:0]  held_index;
    drive_t              drive;
    logic [CFG_W-1:0]    hs_limit;
    logic [CFG_W-1:0]    start_limit;

    line_result_t line_results_q[$];
    int           mismatches;

    // Advances the line state machine by one sampling tick.
    task automatic step_link(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] txb,
                             input logic [INDEX_W-1:0] idx, input logic ring,
                             input logic tip, output line_result_t res);
        logic             met;
        logic             bit_end;
        logic             rx;
        logic [CFG_W-1:0] limit;
        met = 1'b0;
        bit_end = 1'b0;
        limit = hs_limit;
        res = '0;
        case (ph)
            PH_IDLE:
            begin
                if (f == FN_SEND || f == FN_RECV)
                begin
                    held_index = idx;
                    bit_pos = '0;
                    wait_cnt = '0;
                    drive = DRV_NONE;
                    shreg = (f == FN_SEND) ? txb : '0;
                    ph = (f == FN_SEND) ? PH_TX_IDLE : PH_RX_START;
                end
            end
            PH_TX_IDLE:
            begin
                met = ring && tip;
                if (met)
                begin
                    drive = shreg[0] ? DRV_RING : DRV_TIP;
                    ph = shreg[0] ? PH_TX1_TIPLO : PH_TX0_RINGLO;
                end
            end
            PH_TX1_TIPLO:
            begin
                met = !tip;
                if (met)
                begin
                    drive = DRV_NONE;
                    ph = PH_TX1_TIPHI;
                end
            end
            PH_TX1_TIPHI:
            begin
                met = tip;
                if (met)
                begin
                    shreg = shreg >> 1;
                    bit_end = 1'b1;
                end
            end
            PH_TX0_RINGLO:
            begin
                met = !ring;
                if (met)
                begin
                    drive = DRV_NONE;
                    ph = PH_TX0_RINGHI;
                end
            end
            PH_TX0_RINGHI:
            begin
                met = ring;
                if (met)
                begin
                    shreg = shreg >> 1;
                    bit_end = 1'b1;
                end
            end
            PH_RX_START:
            begin
                limit = start_limit;
                met = !(ring && tip);
                if (met)
                begin
                    // Ring low with tip high is a one; any other start is a zero.
                    if (!ring && tip)
                    begin
                        shreg = {1'b1, shreg[BYTE_W-1:1]};
                        drive = DRV_TIP;
                        ph = PH_RX1_RINGHI;
                    end
                    else
                    begin
                        shreg = {1'b0, shreg[BYTE_W-1:1]};
                        drive = DRV_RING;
                        ph = PH_RX0_TIPHI;
                    end
                end
            end
            PH_RX1_RINGHI:
            begin
                met = ring;
                if (met)
                begin
                    drive = DRV_NONE;
                    bit_end = 1'b1;
                end
            end
            PH_RX0_TIPHI:
            begin
                met = tip;
                if (met)
                begin
                    drive = DRV_NONE;
                    bit_end = 1'b1;
                end
            end
            default:
            begin
                ph = PH_IDLE;
                drive = DRV_NONE;
            end
        endcase

        // Bit bookkeeping and the wait timeout; a start tick already counts as a wait.
        if (ph != PH_IDLE && ph <= PH_RX0_TIPHI)
        begin
            if (met)
            begin
                wait_cnt = '0;
                if (bit_end)
                begin
                    rx = (ph >= PH_RX_START);
                    if (bit_pos == 3'd7)
                    begin
                        res.done = 1'b1;
                        if (rx)
                            res.rx = shreg;
                        ph = PH_IDLE;
                        bit_pos = '0;
                    end
                    else
                    begin
                        bit_pos = bit_pos + 1'b1;
                        ph = rx ? PH_RX_START : PH_TX_IDLE;
                    end
                end
            end
            else if (wait_cnt >= limit || wait_cnt == {CNT_W{1'b1}})
            begin
                res.ecode = ph;
                res.ebit = bit_pos;
                res.ebyte = held_index;
                ph = PH_IDLE;
                drive = DRV_NONE;
                wait_cnt = '0;
                bit_pos = '0;
            end
            else
            begin
                wait_cnt = wait_cnt + 1'b1;
            end
        end

        res.ring_pull = drive[0];
        res.tip_pull = drive[1];
        res.busy = (ph != PH_IDLE);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Register writes, result checks, then prediction of the newly accepted item.
    always @(posedge clk or negedge rst_n)
    begin
        line_result_t want;
        line_result_t fresh;
        if (!rst_n)
        begin
            ph = PH_IDLE;
            bit_pos = '0;
            shreg = '0;
            wait_cnt = '0;
            held_index = '0;
            drive = DRV_NONE;
            hs_limit = HANDSHAKE_TIMEOUT_RST;
            start_limit = START_TIMEOUT_RST;
            line_results_q.delete();
            mismatches = 0;
            fail_count <= 0;
            pending <= 0;
            link_busy <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_HANDSHAKE_TIMEOUT)
                    hs_limit = cfg_data;
                else if (cfg_index == REG_START_TIMEOUT)
                    start_limit = cfg_data;
            end

            if (out_valid && !out_stall)
            begin
                if (line_results_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result mismatch, expected no item, got one", $time);
                end
                else
                begin
                    want = line_results_q.pop_front();
                    compare_field("ring_pull_low", want.ring_pull, ring_pull_low);
                    compare_field("tip_pull_low", want.tip_pull, tip_pull_low);
                    compare_field("busy_res", want.busy, busy_res);
                    compare_field("done_res", want.done, done_res);
                    compare_field("rx_byte", want.rx, rx_byte);
                    compare_field("error_code", want.ecode, error_code);
                    compare_field("error_bit", want.ebit, error_bit);
                    compare_field("error_byte", want.ebyte, error_byte);
                end
            end

            if (in_valid && !in_stall)
            begin
                step_link(func, tx_byte, byte_index, ring_level, tip_level, fresh);
                line_results_q.push_back(fresh);
            end

            fail_count <= mismatches;
            pending <= line_results_q.size();
            link_busy <= (ph != PH_IDLE);
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import twlbt_pkg::*;

    // Codes that the package leaves unnamed but the ports can carry
    localparam logic [FUNC_W-1:0]    FN_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [FUNC_W-1:0]    func;
    logic [BYTE_W-1:0]    tx_byte;
    logic [INDEX_W-1:0]   byte_index;
    logic                 ring_level;
    logic                 tip_level;
    logic                 out_valid;
    logic                 out_stall;
    logic                 ring_pull_low;
    logic                 tip_pull_low;
    logic                 busy_res;
    logic                 done_res;
    logic [BYTE_W-1:0]    rx_byte;
    logic [ECODE_W-1:0]   error_code;
    logic [BITPOS_W-1:0]  error_bit;
    logic [INDEX_W-1:0]   error_byte;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int   fail_count;
    int   pending;
    logic link_busy;

    int n_items;
    int delay_odds;
    bit quiet_in;
    bit quiet_out;

    two_wire_link_bit_transceiver_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .tx_byte       (tx_byte),
        .byte_index    (byte_index),
        .ring_level    (ring_level),
        .tip_level     (tip_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ring_pull_low (ring_pull_low),
        .tip_pull_low  (tip_pull_low),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .rx_byte       (rx_byte),
        .error_code    (error_code),
        .error_bit     (error_bit),
        .error_byte    (error_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    twlbt_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .tx_byte       (tx_byte),
        .byte_index    (byte_index),
        .ring_level    (ring_level),
        .tip_level     (tip_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ring_pull_low (ring_pull_low),
        .tip_pull_low  (tip_pull_low),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .rx_byte       (rx_byte),
        .error_code    (error_code),
        .error_bit     (error_bit),
        .error_byte    (error_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .link_busy     (link_busy)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: before taking each item, stalls for a random span or not at all.
    initial
    begin
        int hold;
        out_stall <= 1'b0;
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                quiet_out = !quiet_out;
            hold = quiet_out ? 0 : $urandom_range(0, 19);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Presents one item after a random gap and holds it until it is accepted.
    // The line levels are packed as {ring, tip}.
    task automatic put_tick(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] b,
                            input logic [INDEX_W-1:0] idx, input logic [1:0] lv);
        int gap;
        if ($urandom_range(0, 31) == 0)
            quiet_in = !quiet_in;
        gap = quiet_in ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        tx_byte <= b;
        byte_index <= idx;
        ring_level <= lv[1];
        tip_level <= lv[0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_items++;
    endtask

    // Mostly plain ticks; now and then a start that lands while a byte is in flight.
    function automatic logic [FUNC_W-1:0] side_func();
        return ($urandom_range(0, 15) == 0) ? FUNC_W'($urandom_range(0, 3)) : FN_TICK;
    endfunction

    task automatic line_tick(input logic [1:0] lv);
        put_tick(side_func(), BYTE_W'($urandom), INDEX_W'($urandom), lv);
    endtask

    // The partner is late now and then, which may run into the timeout.
    task automatic dawdle(input logic [1:0] lv);
        int n;
        n = ($urandom_range(0, delay_odds - 1) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) line_tick(lv);
    endtask

    // A partner that takes one byte sent by the block.
    task automatic send_seq();
        logic [BYTE_W-1:0] data;
        data = BYTE_W'($urandom);
        put_tick(FN_SEND, data, INDEX_W'($urandom), 2'($urandom));
        for (int i = 0; i < BYTE_W; i++)
        begin
            dawdle(2'($urandom_range(0, 2)));
            line_tick(2'b11);
            if (data[i])
            begin
                dawdle(2'b01);
                line_tick(2'b00);
                dawdle(2'b10);
            end
            else
            begin
                dawdle(2'b10);
                line_tick(2'b00);
                dawdle(2'b01);
            end
            line_tick(2'b11);
        end
    endtask

    // A partner that sends one byte to the block.
    task automatic recv_seq();
        logic [BYTE_W-1:0] data;
        data = BYTE_W'($urandom);
        put_tick(FN_RECV, BYTE_W'($urandom), INDEX_W'($urandom), 2'($urandom));
        for (int i = 0; i < BYTE_W; i++)
        begin
            dawdle(2'b11);
            if (data[i])
            begin
                line_tick(2'b01);
                dawdle(2'b00);
                line_tick(2'b10);
            end
            else
            begin
                line_tick($urandom_range(0, 1) ? 2'b10 : 2'b00);
                dawdle($urandom_range(0, 1) ? 2'b10 : 2'b00);
                line_tick(2'b01);
            end
        end
    endtask

    task automatic noise_seq();
        repeat ($urandom_range(5, 15))
            put_tick(FUNC_W'($urandom), BYTE_W'($urandom), INDEX_W'($urandom), 2'($urandom));
    endtask

    // Stops the input and waits until every predicted result has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Brings the block back to idle with random line activity.
    task automatic settle();
        drain();
        while (link_busy)
        begin
            repeat (8)
                put_tick(FN_TICK, BYTE_W'($urandom), INDEX_W'($urandom), 2'($urandom));
            drain();
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] hs, input logic [CFG_W-1:0] st,
                             input int budget, input int odds);
        int stop_at;
        int pick;
        settle();
        write_reg(REG_HANDSHAKE_TIMEOUT, hs);
        write_reg(REG_START_TIMEOUT, st);
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
        delay_odds = odds;
        stop_at = n_items + budget;
        while (n_items < stop_at)
        begin
            pick = $urandom_range(0, 11);
            if (pick < 5)
                send_seq();
            else if (pick < 9)
                recv_seq();
            else if (pick < 11)
                noise_seq();
            else
                drain();
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        func <= FN_TICK;
        tx_byte <= '0;
        byte_index <= '0;
        ring_level <= 1'b1;
        tip_level <= 1'b1;
        cfg_valid <= 1'b0;
        cfg_index <= REG_HANDSHAKE_TIMEOUT;
        cfg_data <= '0;
        n_items = 0;
        delay_odds = 8;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tight timeouts so that every stall below ends in an error.
        write_reg(REG_HANDSHAKE_TIMEOUT, 24'd1);
        write_reg(REG_START_TIMEOUT, 24'd2);
        write_reg(REG_SPARE_A, 24'hFFFFFF);
        write_reg(REG_SPARE_B, 24'h000000);

        // Idle ticks, one with the unused function code.
        put_tick(FN_UNUSED, 8'h00, 16'h0000, 2'b11);
        put_tick(FN_TICK, 8'hFF, 16'hFFFF, 2'b00);
        // Send that never sees both lines idle.
        put_tick(FN_SEND, 8'hFF, 16'hFFFF, 2'b00);
        put_tick(FN_TICK, 8'h00, 16'h0000, 2'b01);
        // Receive whose partner never starts a bit.
        put_tick(FN_RECV, 8'hFF, 16'h0000, 2'b00);
        repeat (2) put_tick(FN_TICK, 8'h00, 16'h0000, 2'b11);
        // A one that never sees tip low, with a second send while busy.
        put_tick(FN_SEND, 8'hFF, 16'h5A5A, 2'b11);
        put_tick(FN_TICK, 8'h00, 16'h0000, 2'b11);
        put_tick(FN_SEND, 8'h00, 16'hFFFF, 2'b11);
        put_tick(FN_TICK, 8'h00, 16'h0000, 2'b11);
        // A zero that never sees ring low, with a receive while busy.
        put_tick(FN_SEND, 8'h00, 16'hA5A5, 2'b11);
        put_tick(FN_TICK, 8'h00, 16'h0000, 2'b11);
        put_tick(FN_RECV, 8'hFF, 16'h0000, 2'b11);
        put_tick(FN_TICK, 8'h00, 16'h0000, 2'b11);
        // Received one whose partner keeps ring low.
        put_tick(FN_RECV, 8'h00, 16'h1234, 2'b11);
        put_tick(FN_TICK, 8'h00, 16'h0000, 2'b01);
        put_tick(FN_RECV, 8'h00, 16'h0000, 2'b00);
        put_tick(FN_TICK, 8'h00, 16'h0000, 2'b00);
        // Received zero, both lines low at the start, partner keeps tip low.
        put_tick(FN_RECV, 8'h00, 16'hEDCB, 2'b11);
        put_tick(FN_TICK, 8'h00, 16'h0000, 2'b00);
        repeat (2) put_tick(FN_TICK, 8'h00, 16'h0000, 2'b10);

        // Random traffic under a range of timeout settings.
        run_phase(24'd4000, 24'd30000, 60, 8);
        run_phase(24'd1, 24'd1, 45, 16);
        run_phase(24'd2, 24'd3, 45, 6);
        run_phase(24'hFFFFFF, 24'hFFFFFF, 60, 4);
        run_phase(24'd0, 24'hFFFFFF, 15, 4);
        run_phase(24'd3, 24'd16, 35, 8);
        settle();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
